>>> src/integer_to_radix_ascii_core_assert.svh
// Assertion macros shared by the integer-to-radix-ASCII core.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef INTEGER_TO_RADIX_ASCII_CORE_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ITOA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ITOA_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ITOA_ASSERT(label, clk, rst, prop, msg)
`define ITOA_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

>>> src/itoa_pkg.sv
// Package for the integer-to-radix-ASCII core: sizes, command and status types,
// and the radix clamp and digit-to-character functions. Depends on nothing.
`default_nettype none
package itoa_pkg;

   localparam int VALUE_FIELD_BITS = 32;
   localparam int VALUE_BITS       = 32;
   localparam int MAX_DIGITS       = 32;
   localparam int RADIX_BITS       = 6;
   localparam int CHAR_BITS        = 7;
   localparam int BITS_PER_CYCLE   = 8;

   localparam int DIV_CYCLES = (VALUE_BITS + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
   localparam int DIV_BITS   = DIV_CYCLES * BITS_PER_CYCLE;
   localparam int WIDE_BITS  = (DIV_BITS > VALUE_FIELD_BITS) ? DIV_BITS : VALUE_FIELD_BITS;
   localparam int STEP_BITS  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int CNT_BITS   = $clog2(MAX_DIGITS + 1);
   localparam int IDX_BITS   = $clog2(MAX_DIGITS);

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
   localparam logic [RADIX_BITS-1:0] DIGIT_MAX   = RADIX_BITS'(35);
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO   = CHAR_BITS'(48);
   localparam logic [CHAR_BITS-1:0]  CHAR_LETTER = CHAR_BITS'(55);

   typedef struct packed {
      logic load;
      logic div_step;
      logic digit_done;
      logic emit_read;
      logic emit_out;
   } cmd_type;

   typedef struct packed {
      logic quot_zero;
      logic count_full;
      logic emit_last;
   } status_type;

   function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] res;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end else begin
         res = r;
      end
      return res;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [RADIX_BITS-1:0] d);
      logic [RADIX_BITS-1:0] dc;
      logic [CHAR_BITS-1:0]  res;
      dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
      if (dc < RADIX_BITS'(10)) begin
         res = CHAR_ZERO + CHAR_BITS'(dc);
      end else begin
         res = CHAR_LETTER + CHAR_BITS'(dc);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

>>> src/itoa_ctrl.sv
// Controller state machine for the integer-to-radix-ASCII core.
// Depends on itoa_pkg and the assertion macro header.
`default_nettype none
`include "integer_to_radix_ascii_core_assert.svh"
module itoa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire itoa_pkg::status_type status,
   output itoa_pkg::cmd_type       cmd
);
   import itoa_pkg::*;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_DIV     = 2'd1;
   localparam logic [1:0] S_EMIT_RD = 2'd2;
   localparam logic [1:0] S_EMIT_WR = 2'd3;

   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(DIV_CYCLES - 1);

   logic [1:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_LAST) begin
               cmd.digit_done = 1'b1;
               step_in        = '0;
               if (status.quot_zero || status.count_full) begin
                  state_in = S_EMIT_RD;
               end
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         S_EMIT_RD: begin
            cmd.emit_read = 1'b1;
            state_in      = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            cmd.emit_out = 1'b1;
            state_in     = status.emit_last ? S_IDLE : S_EMIT_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `ITOA_ASSERT(a_start_busy, clock, reset, (start && !busy) |=> busy,
                "Accepted transfer did not make the core busy.")
   `ITOA_ASSERT(a_cmd_onehot, clock, reset,
                $onehot0({cmd.load, cmd.div_step, cmd.emit_read, cmd.emit_out}),
                "More than one datapath command issued in one cycle.")
   `ITOA_ASSERT(a_done_after_last, clock, reset,
                $fell(busy) |-> ($past(reset) || $past(cmd.emit_out && status.emit_last)),
                "Core went idle before the last character was sent.")
endmodule
`default_nettype wire

>>> src/itoa_dpath.sv
// Datapath for the integer-to-radix-ASCII core: radix register, multi-bit restoring
// divider, digit memory and result registers. Depends on itoa_pkg and the macro header.
`default_nettype none
`include "integer_to_radix_ascii_core_assert.svh"
module itoa_dpath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   input  wire logic [itoa_pkg::RADIX_BITS-1:0] csr_radix,
   input  wire logic [itoa_pkg::VALUE_FIELD_BITS-1:0] req_value,
   input  wire itoa_pkg::cmd_type               cmd,
   output itoa_pkg::status_type                 status,
   output logic                                 rsp_strobe,
   output logic [itoa_pkg::CHAR_BITS-1:0]       rsp_digit_char,
   output logic                                 rsp_last_digit
);
   import itoa_pkg::*;

   logic [RADIX_BITS-1:0] radix_ff;
   logic [DIV_BITS-1:0]   quot_ff, quot_in;
   logic [RADIX_BITS:0]   rem_ff, rem_in;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   emit_ff;
   logic [RADIX_BITS-1:0] rd_data_ff;
   logic                  strobe_ff;
   logic [CHAR_BITS-1:0]  char_ff;
   logic                  last_ff;
   logic [RADIX_BITS-1:0] digit_mem [MAX_DIGITS];

   logic [WIDE_BITS-1:0]  wide_value;
   logic [RADIX_BITS:0]   divisor;
   logic [CNT_BITS-1:0]   rd_addr;

   assign wide_value = WIDE_BITS'(req_value) & ~({WIDE_BITS{1'b1}} << VALUE_BITS);
   assign divisor    = {1'b0, radix_ff};
   assign rd_addr    = count_ff - CNT_BITS'(1) - emit_ff;

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         rem_in  = {rem_in[RADIX_BITS-1:0], quot_in[DIV_BITS-1]};
         quot_in = quot_in << 1;
         if (rem_in >= divisor) begin
            rem_in     = rem_in - divisor;
            quot_in[0] = 1'b1;
         end
      end
   end

   assign status.quot_zero  = (quot_in == '0);
   assign status.count_full = (count_ff == CNT_BITS'(MAX_DIGITS - 1));
   assign status.emit_last  = ((emit_ff + CNT_BITS'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= RADIX_RESET;
         count_ff  <= '0;
         emit_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            radix_ff <= clamp_radix(csr_radix);
         end
         strobe_ff <= cmd.emit_out;
         if (cmd.load) begin
            count_ff <= '0;
            emit_ff  <= '0;
         end else begin
            if (cmd.digit_done) begin
               count_ff <= count_ff + CNT_BITS'(1);
            end
            if (cmd.emit_out) begin
               emit_ff <= emit_ff + CNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quot_ff <= wide_value[DIV_BITS-1:0];
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= cmd.digit_done ? '0 : rem_in;
      end
      if (cmd.emit_out) begin
         char_ff <= digit_to_char(rd_data_ff);
         last_ff <= status.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.digit_done) begin
         digit_mem[count_ff[IDX_BITS-1:0]] <= rem_in[RADIX_BITS-1:0];
      end
      if (cmd.emit_read) begin
         rd_data_ff <= digit_mem[rd_addr[IDX_BITS-1:0]];
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

   `ITOA_ASSERT(a_strobe_gap, clock, reset, rsp_strobe |=> !rsp_strobe,
                "Two characters were sent in back-to-back cycles.")
   `ITOA_ASSERT_NEVER(a_store_overflow, clock, reset,
                      cmd.digit_done && (count_ff >= CNT_BITS'(MAX_DIGITS)),
                      "Digit written beyond the end of the digit store.")
   `ITOA_ASSERT(a_radix_range, clock, reset,
                (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX),
                "Radix register holds a value outside the supported range.")
endmodule
`default_nettype wire

>>> src/integer_to_radix_ascii_core.sv
// Top level of the integer-to-radix-ASCII core: joins controller and datapath.
// Depends on itoa_pkg, itoa_ctrl and itoa_dpath.
//
// A value is taken when start is high and busy is low, and is converted in the radix held
// in the csr register (written values below 2 or above 36 are clamped). Each digit comes
// from a restoring divider that retires eight quotient bits per cycle, and each character
// then takes a digit memory read followed by a write to the output register. Characters
// come most significant first, each on the rsp ports for exactly one cycle while
// rsp_strobe is high, never in two consecutive cycles, with rsp_last_digit set on the
// final one. The receiver cannot stall, so it must take every transfer in the cycle it
// is shown. Zero gives "0".
`default_nettype none
module integer_to_radix_ascii_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [itoa_pkg::VALUE_FIELD_BITS-1:0] req_value,
   output logic                                       rsp_strobe,
   output logic [itoa_pkg::CHAR_BITS-1:0]             rsp_digit_char,
   output logic                                       rsp_last_digit,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [itoa_pkg::RADIX_BITS-1:0]       csr_radix
);
   import itoa_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   itoa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   itoa_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid && csr_ready),
      .csr_radix      (csr_radix),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );
endmodule
`default_nettype wire
